// File: hw/rtl/lfu_min_heap_tracker_unit_assert.svh
// Assertion macros for the heap tracker.
`ifndef LFU_MIN_HEAP_TRACKER_UNIT_ASSERT_SVH
`define LFU_MIN_HEAP_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LMH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define LMH_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define LMH_ASSERT(label, clk, rst, prop)
`define LMH_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hw/rtl/lmh_pkg.sv
`default_nettype none
package lmh_pkg;
  localparam int IdW = 16;
  localparam int CntW = 16;
  localparam int StampW = 32;
  localparam int EntryW = IdW + CntW + StampW;

  typedef logic [1:0] mode_t;
  localparam mode_t ModePush = 2'd0;
  localparam mode_t ModeRemove = 2'd1;

  typedef logic [1:0] status_t;
  localparam status_t StatusOk = 2'd0;
  localparam status_t StatusFull = 2'd1;
  localparam status_t StatusAbsent = 2'd2;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [CntW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    StIdle, StSearchRd, StSearchCmp, StApply, StLastRd, StLastLd, StUpRd, StUpCmp,
    StDnRdL, StDnRdR, StDnCmp, StRootRd, StRootLd, StDone
  } state_t;

  function automatic logic ranks_before(entry_t a, entry_t b);
    if (a.count != b.count) return a.count < b.count;
    return a.stamp < b.stamp;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/lmh_req_if.sv
`default_nettype none
interface lmh_req_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [15:0] item_id;
  modport source (output valid, mode, item_id, input ready);
  modport sink (input valid, mode, item_id, output ready);
endinterface

interface lmh_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [15:0] item_count;
  logic front_valid;
  logic [15:0] front_id;
  logic [5:0] entry_total;
  modport source (output valid, status, item_count, front_valid, front_id, entry_total,
    input ready);
  modport sink (input valid, status, item_count, front_valid, front_id, entry_total,
    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lmh_ram.sv
`default_nettype none
module lmh_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AddrW-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/lfu_min_heap_tracker_unit.sv
// channel | direction | fields
// req     | in        | mode, item_id
// rsp     | out       | status, item_count, front_valid, front_id, entry_total
// One request at a time. After accept, the id search reads the heap memory
// once per entry searched, then an apply step, a fetch of the last entry on a
// remove, a parent read and compare per level up, a left-child read and a
// right-child read and compare per level down, a reload of the root, and the
// response. Reset clears size and arrival counter; the memory is not cleared,
// only entries below the size are read.
// A pending response stalls only the next request, never the sift.
`default_nettype none
`include "lfu_min_heap_tracker_unit_assert.svh"
module lfu_min_heap_tracker_unit #(
  parameter int CAPACITY = 32
) (
  input wire logic clk,
  input wire logic rst,
  lmh_req_if.sink req,
  lmh_rsp_if.source rsp
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 1;

  lmh_pkg::state_t state, state_next;
  logic [SW-1:0] size;
  logic [31:0] arrival;
  logic [1:0] mode;
  logic [15:0] id;
  logic [SW-1:0] idx;
  logic found;
  logic [AW-1:0] slot;
  lmh_pkg::entry_t cur, lch;
  logic [AW-1:0] pos;
  logic has_r;
  lmh_pkg::status_t status;
  logic [15:0] count;
  logic [15:0] front_id;

  logic we;
  logic [AW-1:0] waddr, raddr;
  lmh_pkg::entry_t wdata, rdata;

  logic [LW-1:0] par_w, lc_w;
  logic [AW-1:0] par, rc;
  logic full, last_hole, up_move, lc_out, dn_move;
  logic [15:0] cnt_inc;
  lmh_pkg::entry_t best;
  logic best_r;
  logic [AW-1:0] best_idx;

  lmh_ram #(.Width(lmh_pkg::EntryW), .Depth(CAPACITY), .AddrW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign par_w = ({1'b0, pos} - 1'b1) >> 1;
  assign par = par_w[AW-1:0];
  assign lc_w = {pos, 1'b1};
  assign rc = lc_w[AW-1:0] + 1'b1;

  assign full = (size >= SW'(CAPACITY));
  assign last_hole = (SW'(slot) < size - 1'b1);
  assign cnt_inc = (cur.count == '1) ? cur.count : cur.count + 1'b1;
  assign up_move = lmh_pkg::ranks_before(cur, rdata);
  assign lc_out = (lc_w >= LW'(size));
  assign best_r = has_r && lmh_pkg::ranks_before(rdata, lch);
  assign best = best_r ? rdata : lch;
  assign best_idx = best_r ? rc : lc_w[AW-1:0];
  assign dn_move = lmh_pkg::ranks_before(best, cur);

  always_comb begin
    state_next = state;
    unique case (state)
      lmh_pkg::StIdle: if (req.valid && req.ready) state_next = lmh_pkg::StSearchRd;
      lmh_pkg::StSearchRd:
        state_next = (idx < size) ? lmh_pkg::StSearchCmp : lmh_pkg::StApply;
      lmh_pkg::StSearchCmp:
        state_next = (rdata.id == id) ? lmh_pkg::StApply : lmh_pkg::StSearchRd;
      lmh_pkg::StApply: begin
        state_next = lmh_pkg::StRootRd;
        if (found) begin
          if (mode == lmh_pkg::ModePush) state_next = lmh_pkg::StDnRdL;
          else if (mode == lmh_pkg::ModeRemove && last_hole) state_next = lmh_pkg::StLastRd;
        end else if (mode == lmh_pkg::ModePush && !full) begin
          state_next = lmh_pkg::StUpRd;
        end
      end
      lmh_pkg::StLastRd: state_next = lmh_pkg::StLastLd;
      lmh_pkg::StLastLd: state_next = lmh_pkg::StUpRd;
      lmh_pkg::StUpRd: state_next = (pos == '0) ? lmh_pkg::StDnRdL : lmh_pkg::StUpCmp;
      lmh_pkg::StUpCmp: state_next = up_move ? lmh_pkg::StUpRd : lmh_pkg::StDnRdL;
      lmh_pkg::StDnRdL: state_next = lc_out ? lmh_pkg::StRootRd : lmh_pkg::StDnRdR;
      lmh_pkg::StDnRdR: state_next = lmh_pkg::StDnCmp;
      lmh_pkg::StDnCmp: state_next = dn_move ? lmh_pkg::StDnRdL : lmh_pkg::StRootRd;
      lmh_pkg::StRootRd: state_next = lmh_pkg::StRootLd;
      lmh_pkg::StRootLd: state_next = lmh_pkg::StDone;
      lmh_pkg::StDone: if (rsp.ready) state_next = lmh_pkg::StIdle;
      default: state_next = lmh_pkg::StIdle;
    endcase
  end

  assign req.ready = (state == lmh_pkg::StIdle);
  assign rsp.valid = (state == lmh_pkg::StDone);
  assign rsp.status = status;
  assign rsp.item_count = count;
  assign rsp.front_valid = (size != '0);
  assign rsp.front_id = (size != '0) ? front_id : '0;
  assign rsp.entry_total = 6'(size);

  // The moving entry stays in cur; the hole it leaves is filled by the entry
  // that moves the other way, and cur lands where the sift stops.
  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = idx[AW-1:0];
    unique case (state)
      lmh_pkg::StLastRd: raddr = size[AW-1:0];
      lmh_pkg::StUpRd: raddr = par;
      lmh_pkg::StUpCmp: begin
        if (up_move) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      lmh_pkg::StDnRdL: begin
        raddr = lc_w[AW-1:0];
        we = lc_out;
      end
      lmh_pkg::StDnRdR: raddr = rc;
      lmh_pkg::StDnCmp: begin
        we = 1'b1;
        if (dn_move) wdata = best;
      end
      lmh_pkg::StRootRd: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lmh_pkg::StIdle;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      arrival <= '0;
    end else begin
      unique case (state)
        lmh_pkg::StIdle: begin
          if (req.valid && req.ready) begin
            mode <= req.mode; id <= req.item_id; idx <= '0; found <= 1'b0;
            status <= lmh_pkg::StatusOk; count <= '0;
          end
        end
        lmh_pkg::StSearchCmp: begin
          if (rdata.id == id) begin
            found <= 1'b1; slot <= idx[AW-1:0]; cur <= rdata;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        lmh_pkg::StApply: begin
          if (mode == lmh_pkg::ModePush) begin
            if (found) begin
              cur.count <= cnt_inc;
              count <= cnt_inc;
              pos <= slot;
            end else if (full) begin
              status <= lmh_pkg::StatusFull;
            end else begin
              cur <= '{id: id, count: 16'd1, stamp: arrival};
              arrival <= arrival + 1'b1;
              pos <= size[AW-1:0];
              size <= size + 1'b1;
              count <= 16'd1;
            end
          end else if (mode == lmh_pkg::ModeRemove) begin
            if (!found) begin
              status <= lmh_pkg::StatusAbsent;
            end else begin
              size <= size - 1'b1;
              pos <= slot;
            end
          end else if (found) begin
            count <= cur.count;
          end
        end
        // Remove: pull the last entry into the hole, then re-sift it.
        lmh_pkg::StLastLd: cur <= rdata;
        lmh_pkg::StUpCmp: if (up_move) pos <= par;
        lmh_pkg::StDnRdL: has_r <= (lc_w + 1'b1) < LW'(size);
        lmh_pkg::StDnRdR: lch <= rdata;
        lmh_pkg::StDnCmp: if (dn_move) pos <= best_idx;
        lmh_pkg::StRootLd: front_id <= rdata.id;
        default: ;
      endcase
    end
  end

  `LMH_ASSERT(a_one_hot_hs, clk, rst, !(req.ready && rsp.valid))
  `LMH_ASSERT(a_size_cap, clk, rst, size <= SW'(CAPACITY))
  `LMH_ASSERT(a_full_keeps, clk, rst,
    (rsp.valid && rsp.status == lmh_pkg::StatusFull) |-> size == SW'(CAPACITY))
endmodule
`default_nettype wire
